### hdl/ccs_pkg.sv
// Package of the calorimeter cone energy sum block.
// Holds the controller states, the command and status structs, the register
// indexes and the fixed-point constants. No dependencies.
package ccs_pkg;

	localparam int POS_W    = 20;
	localparam int ENERGY_W = 24;
	localparam int SUB_W    = 3;
	localparam int SUM_W    = 48;
	localparam int ANGLE_W  = 16;
	localparam int RAD_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int RADICAND_W = 56;
	localparam int ROOT_W     = 28;
	localparam int LOGIN_W    = 29;
	localparam int LOG_W      = 21;

	localparam int SQRT_STEPS   = 28;
	localparam int CORDIC_STEPS = 16;
	localparam int LOG_STEPS    = 16;
	localparam int CNT_W        = 5;

	localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic [15:0]        LN2_Q16     = 16'd45426;
	localparam logic [14:0]        Q12_MAX     = 15'd32767;
	localparam logic [4:0]         NORM_TOP    = 5'd30;

	localparam logic [15:0] RST_CONE_RADIUS   = 16'd819;
	localparam logic [23:0] RST_HIT_THRESHOLD = 24'd2000;
	localparam logic [23:0] RST_GAIN_EB       = 24'd69941;
	localparam logic [23:0] RST_GAIN_EE       = 24'd69941;
	localparam logic [23:0] RST_GAIN_HB       = 24'd3224573;
	localparam logic [23:0] RST_GAIN_HE       = 24'd3514456;
	localparam logic [23:0] RST_GAIN_HR       = 24'd4077219;
	localparam int NUM_GAINS = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CONE_RADIUS   = 3'd0,
		REG_HIT_THRESHOLD = 3'd1,
		REG_GAIN_EB       = 3'd2,
		REG_GAIN_EE       = 3'd3,
		REG_GAIN_HB       = 3'd4,
		REG_GAIN_HE       = 3'd5,
		REG_GAIN_HR       = 3'd6
	} ccs_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_SQLD,
		S_SQRT,
		S_NLOAD,
		S_NORM,
		S_LOG,
		S_ETAM,
		S_ETAF,
		S_TRACK,
		S_SQ,
		S_TEST,
		S_ACC,
		S_OUT
	} ccs_state_t;

	typedef struct packed {
		logic       load;
		logic       prep;
		logic       sqrt_load;
		logic       sqrt_step;
		logic       cordic_step;
		logic [3:0] idx;
		logic       norm_load;
		logic       norm_step;
		logic       log_step;
		logic       eta_mul;
		logic       eta_fin;
		logic       track_store;
		logic       square;
		logic       test;
		logic       accum;
		logic       out_load;
	} ccs_cmd_t;

	typedef struct packed {
		logic is_track;
		logic last;
		logic normed;
		logic out_free;
	} ccs_stat_t;

	// Arctangent of 2^-i in Q.16.
	function automatic logic [15:0] atan_q16(input logic [3:0] i);
		logic [15:0] v;
		case (i)
			4'd0:    v = 16'd51472;
			4'd1:    v = 16'd30386;
			4'd2:    v = 16'd16055;
			4'd3:    v = 16'd8150;
			4'd4:    v = 16'd4091;
			4'd5:    v = 16'd2047;
			4'd6:    v = 16'd1024;
			4'd7:    v = 16'd512;
			4'd8:    v = 16'd256;
			4'd9:    v = 16'd128;
			4'd10:   v = 16'd64;
			4'd11:   v = 16'd32;
			4'd12:   v = 16'd16;
			4'd13:   v = 16'd8;
			4'd14:   v = 16'd4;
			4'd15:   v = 16'd2;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

### hdl/ccs_in_if.sv
// Input channel of the cone energy sum: valid, ready and one item.
// Depends on ccs_pkg for the field widths.
interface ccs_in_if;
	import ccs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic signed [POS_W-1:0]    pos_x;
	logic signed [POS_W-1:0]    pos_y;
	logic signed [POS_W-1:0]    pos_z;
	logic [ENERGY_W-1:0]        hit_energy;
	logic [SUB_W-1:0]           subdetector;
	logic                       last;

	modport source (output valid, cmd, pos_x, pos_y, pos_z, hit_energy, subdetector, last,
		input ready);
	modport sink (input valid, cmd, pos_x, pos_y, pos_z, hit_energy, subdetector, last,
		output ready);
endinterface

### hdl/ccs_out_if.sv
// Output channel of the cone energy sum: valid, ready and one result.
// Depends on ccs_pkg for the field widths.
interface ccs_out_if;
	import ccs_pkg::*;

	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] cone_energy;
	logic             saturated;

	modport source (output valid, cone_energy, saturated, input ready);
	modport sink (input valid, cone_energy, saturated, output ready);
endinterface

### hdl/ccs_sqrt.sv
// Digit-by-digit floor square root, two radicand bits per step.
// Depends on ccs_pkg for the widths.
module ccs_sqrt (
	input  logic                           clk,
	input  logic                           load,
	input  logic [ccs_pkg::RADICAND_W-1:0] radicand,
	input  logic                           step,
	output logic [ccs_pkg::ROOT_W-1:0]     root
);
	import ccs_pkg::*;

	logic [RADICAND_W-1:0] opnd_q;
	logic [ROOT_W+1:0]     rem_q;
	logic [ROOT_W-1:0]     root_q;
	logic [ROOT_W+3:0]     rem_sh;
	logic [ROOT_W+3:0]     trial;
	logic [ROOT_W+3:0]     diff;

	assign rem_sh = {rem_q, opnd_q[RADICAND_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk) begin
		if (load) begin
			opnd_q <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			opnd_q <= {opnd_q[RADICAND_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= diff[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[ROOT_W+1:0];
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

### hdl/ccs_log.sv
// Base-2 logarithm in Q.16: a one-bit-a-cycle normalizer followed by
// sixteen squaring rounds on a Q1.30 mantissa. Depends on ccs_pkg.
module ccs_log (
	input  logic                        clk,
	input  logic                        load,
	input  logic [ccs_pkg::LOGIN_W-1:0] value,
	input  logic                        norm_step,
	input  logic                        log_step,
	input  logic [3:0]                  idx,
	output logic                        normed,
	output logic [ccs_pkg::LOG_W-1:0]   result
);
	import ccs_pkg::*;

	logic [30:0] m_q;
	logic [4:0]  sh_q;
	logic [15:0] frac_q;
	logic [61:0] sq;
	logic [31:0] t;

	assign sq = 62'(m_q) * 62'(m_q);
	assign t  = sq[61:30];
	assign normed = m_q[30];

	always_ff @(posedge clk) begin
		if (load) begin
			m_q    <= {2'b00, value};
			sh_q   <= '0;
			frac_q <= '0;
		end else if (norm_step && !m_q[30]) begin
			m_q  <= {m_q[29:0], 1'b0};
			sh_q <= sh_q + 5'd1;
		end else if (log_step) begin
			// A square of two or more yields a one bit and is halved back.
			if (t[31]) begin
				m_q         <= t[31:1];
				frac_q[idx] <= 1'b1;
			end else begin
				m_q <= t[30:0];
			end
		end
	end

	assign result = {NORM_TOP - sh_q, frac_q};
endmodule

### hdl/ccs_ctrl.sv
// Controller of the cone energy sum: sequences one item through the
// datapath by commands. Depends on ccs_pkg.
module ccs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ccs_pkg::ccs_stat_t  st,
	output ccs_pkg::ccs_cmd_t   cm
);
	import ccs_pkg::*;

	ccs_state_t       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_PREP;
			S_PREP:  state_d = S_SQLD;
			S_SQLD:  state_d = S_SQRT;
			S_SQRT:  if (cnt_q == CNT_W'(SQRT_STEPS - 1)) state_d = S_NLOAD;
			S_NLOAD: state_d = S_NORM;
			S_NORM:  if (st.normed) state_d = S_LOG;
			S_LOG:   if (cnt_q == CNT_W'(LOG_STEPS - 1)) state_d = S_ETAM;
			S_ETAM:  state_d = S_ETAF;
			S_ETAF:  state_d = st.is_track ? S_TRACK : S_SQ;
			S_TRACK: state_d = S_IDLE;
			S_SQ:    state_d = S_TEST;
			S_TEST:  state_d = S_ACC;
			S_ACC:   state_d = st.last ? S_OUT : S_IDLE;
			S_OUT:   if (st.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cm = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cm.load  = in_valid;
			end
			S_PREP:  cm.prep = 1'b1;
			S_SQLD:  cm.sqrt_load = 1'b1;
			S_SQRT: begin
				cm.sqrt_step   = 1'b1;
				cm.cordic_step = cnt_q < CNT_W'(CORDIC_STEPS);
				cm.idx         = cnt_q[3:0];
			end
			S_NLOAD: cm.norm_load = 1'b1;
			S_NORM:  cm.norm_step = 1'b1;
			S_LOG: begin
				cm.log_step = 1'b1;
				cm.idx      = 4'd15 - cnt_q[3:0];
			end
			S_ETAM:  cm.eta_mul = 1'b1;
			S_ETAF:  cm.eta_fin = 1'b1;
			S_TRACK: cm.track_store = 1'b1;
			S_SQ:    cm.square = 1'b1;
			S_TEST:  cm.test = 1'b1;
			S_ACC:   cm.accum = 1'b1;
			S_OUT:   cm.out_load = st.out_free;
			default: cm = '0;
		endcase
	end
endmodule

### hdl/ccs_dp.sv
// Datapath of the cone energy sum: configuration registers, CORDIC for phi,
// square roots and logarithms for eta, cone test and saturating sum.
// Depends on ccs_pkg, ccs_sqrt and ccs_log.
module ccs_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ccs_pkg::ccs_cmd_t                cm,
	output ccs_pkg::ccs_stat_t               st,
	input  logic                             cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_cmd,
	input  logic signed [ccs_pkg::POS_W-1:0] in_x,
	input  logic signed [ccs_pkg::POS_W-1:0] in_y,
	input  logic signed [ccs_pkg::POS_W-1:0] in_z,
	input  logic [ccs_pkg::ENERGY_W-1:0]     in_energy,
	input  logic [ccs_pkg::SUB_W-1:0]        in_sub,
	input  logic                             in_last,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ccs_pkg::SUM_W-1:0]        out_energy,
	output logic                             out_sat
);
	import ccs_pkg::*;

	// Configuration.
	logic [RAD_W-1:0]    radius_q;
	logic [ENERGY_W-1:0] thr_q;
	logic [ENERGY_W-1:0] gain_q [NUM_GAINS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= RST_CONE_RADIUS;
			thr_q     <= RST_HIT_THRESHOLD;
			gain_q[0] <= RST_GAIN_EB;
			gain_q[1] <= RST_GAIN_EE;
			gain_q[2] <= RST_GAIN_HB;
			gain_q[3] <= RST_GAIN_HE;
			gain_q[4] <= RST_GAIN_HR;
		end else if (cfg_we) begin
			case (ccs_reg_t'(cfg_index))
				REG_CONE_RADIUS:   radius_q  <= cfg_data[RAD_W-1:0];
				REG_HIT_THRESHOLD: thr_q     <= cfg_data;
				REG_GAIN_EB:       gain_q[0] <= cfg_data;
				REG_GAIN_EE:       gain_q[1] <= cfg_data;
				REG_GAIN_HB:       gain_q[2] <= cfg_data;
				REG_GAIN_HE:       gain_q[3] <= cfg_data;
				REG_GAIN_HR:       gain_q[4] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Captured item.
	logic                    cmd_q, last_q;
	logic signed [POS_W-1:0] x_q, y_q, z_q;
	logic [ENERGY_W-1:0]     energy_q;
	logic [SUB_W-1:0]        sub_q;

	always_ff @(posedge clk) begin
		if (cm.load) begin
			cmd_q    <= in_cmd;
			x_q      <= in_x;
			y_q      <= in_y;
			z_q      <= in_z;
			energy_q <= in_energy;
			sub_q    <= in_sub;
			last_q   <= in_last;
		end
	end

	// Magnitudes, squares and CORDIC setup.
	logic [POS_W-1:0]     ax, ay, az;
	logic [2*POS_W-1:0]   ax2_q, ay2_q, az2_q;
	logic [POS_W-1:0]     az_q;
	logic                 zneg_q, phi_zero_q;
	logic signed [31:0]   x256, y256, cx_q, cy_q, sx, sy;
	logic signed [19:0]   acc_q, tab;

	assign ax   = x_q[POS_W-1] ? POS_W'(-x_q) : POS_W'(x_q);
	assign ay   = y_q[POS_W-1] ? POS_W'(-y_q) : POS_W'(y_q);
	assign az   = z_q[POS_W-1] ? POS_W'(-z_q) : POS_W'(z_q);
	assign x256 = {{4{x_q[POS_W-1]}}, x_q, 8'b0};
	assign y256 = {{4{y_q[POS_W-1]}}, y_q, 8'b0};
	assign sx   = cx_q >>> cm.idx;
	assign sy   = cy_q >>> cm.idx;
	assign tab  = 20'(atan_q16(cm.idx));

	always_ff @(posedge clk) begin
		if (cm.prep) begin
			ax2_q      <= 40'(ax) * 40'(ax);
			ay2_q      <= 40'(ay) * 40'(ay);
			az2_q      <= 40'(az) * 40'(az);
			az_q       <= az;
			zneg_q     <= z_q[POS_W-1];
			phi_zero_q <= (x_q == '0) && (y_q == '0);
			// Left half plane is turned by a quarter turn first.
			if (x_q[POS_W-1]) begin
				if (!y_q[POS_W-1]) begin
					cx_q  <= y256;
					cy_q  <= -x256;
					acc_q <= HALF_PI_Q16;
				end else begin
					cx_q  <= -y256;
					cy_q  <= x256;
					acc_q <= -HALF_PI_Q16;
				end
			end else begin
				cx_q  <= x256;
				cy_q  <= y256;
				acc_q <= '0;
			end
		end else if (cm.cordic_step) begin
			if (!cy_q[31] && (cy_q != '0)) begin
				cx_q  <= cx_q + sy;
				cy_q  <= cy_q - sx;
				acc_q <= acc_q + tab;
			end else begin
				cx_q  <= cx_q - sy;
				cy_q  <= cy_q + sx;
				acc_q <= acc_q - tab;
			end
		end
	end

	// Square roots of the transverse and full radii.
	logic [2*POS_W:0]  r2, p2;
	logic [ROOT_W-1:0] rq, pq;

	assign r2 = {1'b0, ax2_q} + {1'b0, ay2_q};
	assign p2 = r2 + {1'b0, az2_q};

	ccs_sqrt u_sqrt_r (
		.clk      (clk),
		.load     (cm.sqrt_load),
		.radicand ({r2[RADICAND_W-17:0], 16'b0}),
		.step     (cm.sqrt_step),
		.root     (rq)
	);

	ccs_sqrt u_sqrt_p (
		.clk      (clk),
		.load     (cm.sqrt_load),
		.radicand ({p2[RADICAND_W-17:0], 16'b0}),
		.step     (cm.sqrt_step),
		.root     (pq)
	);

	// Logarithms of p + |z| and of r.
	logic [LOGIN_W-1:0] a_sum, a_val, r_val;
	logic [LOG_W-1:0]   la, lr;
	logic               norm_a, norm_r, rzero_q;

	assign a_sum = {1'b0, pq} + {1'b0, az_q, 8'b0};
	// Zero operands only occur with a zero radius, where eta is overridden; they are
	// loaded as one so the normalizer ends.
	assign a_val = (a_sum == '0) ? LOGIN_W'(1) : a_sum;
	assign r_val = (rq == '0) ? LOGIN_W'(1) : {1'b0, rq};

	always_ff @(posedge clk) begin
		if (cm.norm_load) rzero_q <= (rq == '0);
	end

	ccs_log u_log_a (
		.clk       (clk),
		.load      (cm.norm_load),
		.value     (a_val),
		.norm_step (cm.norm_step),
		.log_step  (cm.log_step),
		.idx       (cm.idx),
		.normed    (norm_a),
		.result    (la)
	);

	ccs_log u_log_r (
		.clk       (clk),
		.load      (cm.norm_load),
		.value     (r_val),
		.norm_step (cm.norm_step),
		.log_step  (cm.log_step),
		.idx       (cm.idx),
		.normed    (norm_r),
		.result    (lr)
	);

	// Eta and phi.
	logic signed [LOG_W:0]     ldiff;
	logic [LOG_W-1:0]          lclamp;
	logic [LOG_W+15:0]         eta_prod_q;
	logic [LOG_W+16:0]         eta_rnd;
	logic [17:0]               e_full;
	logic [14:0]               e_sat;
	logic signed [ANGLE_W-1:0] eta_d, phi_d, eta_q, phi_q;
	logic signed [19:0]        acc_rnd;

	assign ldiff  = $signed({1'b0, la}) - $signed({1'b0, lr});
	assign lclamp = ldiff[LOG_W] ? '0 : ldiff[LOG_W-1:0];
	assign eta_rnd = {1'b0, eta_prod_q} + (38'd1 << 19);
	assign e_full  = eta_rnd[37:20];
	assign e_sat   = (e_full > 18'(Q12_MAX)) ? Q12_MAX : e_full[14:0];
	assign acc_rnd = (acc_q + 20'sd8) >>> 4;

	always_comb begin
		if (rzero_q) begin
			if (az_q == '0) eta_d = '0;
			else eta_d = zneg_q ? -$signed({1'b0, Q12_MAX}) : $signed({1'b0, Q12_MAX});
		end else begin
			eta_d = zneg_q ? -$signed({1'b0, e_sat}) : $signed({1'b0, e_sat});
		end
		phi_d = phi_zero_q ? '0 : acc_rnd[ANGLE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cm.eta_mul) eta_prod_q <= 37'(lclamp) * 37'(LN2_Q16);
		if (cm.eta_fin) begin
			eta_q <= eta_d;
			phi_q <= phi_d;
		end
	end

	// Cone test and weighted sum.
	logic signed [ANGLE_W-1:0] trk_eta_q, trk_phi_q;
	logic signed [ANGLE_W:0]   deta, dphi;
	logic signed [2*ANGLE_W+1:0] deta_sq, dphi_sq;
	logic [2*ANGLE_W:0]        deta2_q, dphi2_q;
	logic [2*RAD_W-1:0]        rad2_q;
	logic [SUM_W-1:0]          prod_q, sum_q;
	logic [ENERGY_W-1:0]       gain_sel;
	logic                      ok_q, ovf_q;
	logic [SUM_W:0]            sum_add;

	assign deta    = ANGLE_W'(0) + ($signed({eta_q[ANGLE_W-1], eta_q})
		- $signed({trk_eta_q[ANGLE_W-1], trk_eta_q}));
	assign dphi    = ANGLE_W'(0) + ($signed({phi_q[ANGLE_W-1], phi_q})
		- $signed({trk_phi_q[ANGLE_W-1], trk_phi_q}));
	assign deta_sq = deta * deta;
	assign dphi_sq = dphi * dphi;
	assign gain_sel = (sub_q < SUB_W'(NUM_GAINS)) ? gain_q[sub_q[2:0]] : '0;
	assign sum_add  = {1'b0, sum_q} + {1'b0, prod_q};

	always_ff @(posedge clk) begin
		if (cm.square) begin
			deta2_q <= deta_sq[2*ANGLE_W:0];
			dphi2_q <= dphi_sq[2*ANGLE_W:0];
			rad2_q  <= 32'(radius_q) * 32'(radius_q);
			prod_q  <= 48'(energy_q) * 48'(gain_sel);
		end
		if (cm.test) begin
			ok_q <= (({1'b0, deta2_q} + {1'b0, dphi2_q}) < {2'b00, rad2_q})
				&& (energy_q > thr_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_eta_q <= '0;
			trk_phi_q <= '0;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
		end else if (cm.track_store) begin
			trk_eta_q <= eta_q;
			trk_phi_q <= phi_q;
			sum_q     <= '0;
			ovf_q     <= 1'b0;
		end else if (cm.accum && ok_q) begin
			if (sum_add[SUM_W]) begin
				sum_q <= '1;
				ovf_q <= 1'b1;
			end else begin
				sum_q <= sum_add[SUM_W-1:0];
			end
		end
	end

	// Output register.
	logic             out_valid_q;
	logic [SUM_W-1:0] out_energy_q;
	logic             out_sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cm.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cm.out_load) begin
			out_energy_q <= sum_q;
			out_sat_q    <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_energy = out_energy_q;
	assign out_sat    = out_sat_q;

	assign st.is_track = !cmd_q;
	assign st.last     = last_q;
	assign st.normed   = norm_a && norm_r;
	assign st.out_free = !out_valid_q || out_ready;
endmodule

### hdl/calorimeter_cone_energy_sum.sv
// Calorimeter cone energy sum takes one item at a time. A hit passes through more
// states than a track item, and a hit with last set also through the output state.
// The time per item is set by the 28-step square roots and the bit-serial log
// normalizer (up to 30 shifts) followed by sixteen squaring rounds. Track items
// (cmd 0) set the cone axis and clear the sum; hits inside the cone and above
// threshold add energy times gain, and a hit with last set delivers the sum and
// the saturation flag. A result waits in an output register; the next item is
// taken meanwhile, and only a further result stalls until that register is free.
// Configuration is to be written only while idle; this is left to the user.
module calorimeter_cone_energy_sum (
	input  logic                            clk,
	input  logic                            arst_n,
	ccs_in_if.sink                          in_ch,
	ccs_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [ccs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ccs_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import ccs_pkg::*;

	ccs_cmd_t  cm;
	ccs_stat_t st;

	ccs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cm       (cm)
	);

	ccs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cm         (cm),
		.st         (st),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_cmd     (in_ch.cmd),
		.in_x       (in_ch.pos_x),
		.in_y       (in_ch.pos_y),
		.in_z       (in_ch.pos_z),
		.in_energy  (in_ch.hit_energy),
		.in_sub     (in_ch.subdetector),
		.in_last    (in_ch.last),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_energy (out_ch.cone_energy),
		.out_sat    (out_ch.saturated)
	);

	// One item at a time: no second transaction right after an accepted one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while an item is in progress");

	// A clamped sum is reported at its maximum.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.saturated |-> (&out_ch.cone_energy))
		else $error("saturated result is not at full scale");

	// Squaring rounds only run on normalized mantissas.
	a_log_normed: assert property (@(posedge clk) disable iff (!arst_n)
		cm.log_step |-> st.normed)
		else $error("log step on an unnormalized mantissa");

	// A new result is only loaded into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !cm.out_load)
		else $error("pending result overwritten");
endmodule

### dv/tb_top.sv
// Testbench of calorimeter_cone_energy_sum: drives track and hit transactions, predicts
// each cone sum with a bit-exact fixed-point model of eta, phi and the cone test.
// Depends on ccs_pkg, ccs_in_if, ccs_out_if and calorimeter_cone_energy_sum from the RTL.
`timescale 1ns / 1ps

module tb_top;
	import ccs_pkg::*;

	typedef struct {
		logic                    cmd;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [ENERGY_W-1:0]     energy;
		logic [SUB_W-1:0]        sub;
		logic                    last;
	} calo_item_t;

	typedef struct {
		logic [SUM_W-1:0] energy;
		logic             sat;
	} cone_sum_t;

	localparam longint unsigned SUM_LIMIT = 64'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 6000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ccs_in_if in_ch();
	ccs_out_if out_ch();

	calorimeter_cone_energy_sum u_top (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow copy of the configuration and the accumulator state.
	logic [RAD_W-1:0] mdl_radius;
	logic [23:0] mdl_threshold;
	logic [23:0] mdl_gain [NUM_GAINS];
	int trk_eta, trk_phi;
	longint unsigned run_sum;
	logic run_ovf;

	cone_sum_t pending_sums[$];
	int err_cnt = 0;
	int items_sent = 0;
	int sums_seen = 0;
	int hits_in_cone = 0;
	int idle_cnt = 0;
	bit calm = 0;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint log2_q16(longint unsigned v);
		int n;
		longint unsigned t, m;
		longint r;
		if (v == 0) return 0;
		n = 0;
		t = v;
		while (t > 1) begin
			t = t >> 1;
			n++;
		end
		m = (n <= 30) ? (v << (30 - n)) : (v >> (n - 30));
		r = longint'(n) << 16;
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				r += longint'(1) << i;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	function automatic int azimuth_q12(longint x, longint y);
		longint acc, nx, ny;
		acc = 0;
		if (x == 0 && y == 0) return 0;
		x = x * 256;
		y = y * 256;
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; ny = -x; acc = 102944;
			end else begin
				nx = -y; ny = x; acc = -102944;
			end
			x = nx;
			y = ny;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); ny = y - (x >>> i); acc += atan_step(i);
			end else begin
				nx = x - (y >>> i); ny = y + (x >>> i); acc -= atan_step(i);
			end
			x = nx;
			y = ny;
		end
		return int'((acc + 8) >>> 4);
	endfunction

	function automatic longint atan_step(int i);
		longint steps [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		return steps[i];
	endfunction

	function automatic int rapidity_q12(longint x, longint y, longint z);
		longint unsigned ax, ay, az, r2, rq, pq;
		longint l, e;
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		r2 = ax * ax + ay * ay;
		rq = floor_sqrt(r2 << 16);
		pq = floor_sqrt((r2 + az * az) << 16);
		if (rq == 0) begin
			if (az == 0) return 0;
			return (z < 0) ? -32767 : 32767;
		end
		l = log2_q16(pq + (az << 8)) - log2_q16(rq);
		if (l < 0) l = 0;
		e = (l * 45426 + (longint'(1) << 19)) >> 20;
		if (e > 32767) e = 32767;
		return (z < 0) ? -int'(e) : int'(e);
	endfunction

	// Updates the shadow state with one accepted transaction.
	function automatic void accumulate_cone(calo_item_t it);
		longint deta, dphi;
		longint unsigned d2, rad2, gain, prod;
		cone_sum_t res;
		if (it.cmd == 1'b0) begin
			trk_eta = rapidity_q12(it.x, it.y, it.z);
			trk_phi = azimuth_q12(it.x, it.y);
			run_sum = 0;
			run_ovf = 1'b0;
			return;
		end
		deta = rapidity_q12(it.x, it.y, it.z) - trk_eta;
		dphi = azimuth_q12(it.x, it.y) - trk_phi;
		d2 = deta * deta + dphi * dphi;
		rad2 = longint'(mdl_radius) * longint'(mdl_radius);
		gain = (it.sub < NUM_GAINS) ? mdl_gain[it.sub] : 0;
		if (d2 < rad2 && it.energy > mdl_threshold) begin
			hits_in_cone++;
			prod = longint'(it.energy) * gain;
			if (prod > SUM_LIMIT - run_sum) begin
				run_sum = SUM_LIMIT;
				run_ovf = 1'b1;
			end else begin
				run_sum += prod;
			end
		end
		if (it.last) begin
			res.energy = run_sum[SUM_W-1:0];
			res.sat = run_ovf;
			pending_sums.push_back(res);
		end
	endfunction

	task automatic send_item(calo_item_t it);
		@(negedge clk);
		if (!calm && $urandom_range(99) < 17) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(6, 1)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.cmd = it.cmd;
		in_ch.pos_x = it.x;
		in_ch.pos_y = it.y;
		in_ch.pos_z = it.z;
		in_ch.hit_energy = it.energy;
		in_ch.subdetector = it.sub;
		in_ch.last = it.last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		accumulate_cone(it);
		items_sent++;
	endtask

	// Holds the input quiet until every result is back and in-flight items are done.
	task automatic drain();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(ccs_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_CONE_RADIUS:   mdl_radius = val[RAD_W-1:0];
			REG_HIT_THRESHOLD: mdl_threshold = val;
			default:           mdl_gain[int'(idx) - int'(REG_GAIN_EB)] = val;
		endcase
	endtask

	task automatic track(int x, int y, int z);
		calo_item_t it;
		it.cmd = 1'b0;
		it.x = x; it.y = y; it.z = z;
		it.energy = $urandom();
		it.sub = $urandom();
		it.last = $urandom();
		send_item(it);
	endtask

	task automatic hit(int x, int y, int z, int e, int sub, bit last);
		calo_item_t it;
		it.cmd = 1'b1;
		it.x = x; it.y = y; it.z = z;
		it.energy = e;
		it.sub = sub;
		it.last = last;
		send_item(it);
	endtask

	function automatic int clamp_pos(longint v);
		if (v > 524287) return 524287;
		if (v < -524288) return -524288;
		return int'(v);
	endfunction

	function automatic int rand_pos();
		return $signed($urandom()) >>> 12;
	endfunction

	// A coordinate scattered around c by up to about |c| / spread.
	function automatic int jitter(int c, int spread);
		int mag;
		mag = (c < 0) ? -c : c;
		return clamp_pos(c + $signed($urandom()) % (mag / spread + 2));
	endfunction

	task automatic test_directed();
		// Hits before any track use the reset axis.
		hit(1000, 0, 0, 5000, 0, 1);
		hit(1000, 3, 0, 2000, 1, 1);
		track(0, 0, 0);
		hit(0, 0, 0, 16777215, 2, 1);
		// Beam axis saturates eta.
		track(0, 0, 100000);
		hit(0, 0, 5000, 16777215, 2, 0);
		hit(0, 0, -5000, 300000, 3, 1);
		// Negative x on the axis gives phi of plus pi.
		track(-1000, 0, 0);
		hit(-1000, 0, 10, 900000, 5, 0);
		hit(-1000, 0, 10, 900000, 7, 0);
		hit(-1000, 0, 10, 900000, 4, 1);
		hit(-1000, -1, 0, 900000, 3, 1);
		track(524287, -524288, -524288);
		hit(-524288, 524287, 524287, 16777215, 4, 1);
		hit(524287, -524288, -524288, 2001, 0, 1);
		hit(524287, -524288, -524288, 2000, 1, 1);
		hit(524287, -524288, 524287, 0, 6, 1);
		drain();
	endtask

	task automatic test_overflow();
		write_reg(REG_GAIN_HR, 24'hFFFFFF);
		write_reg(REG_GAIN_EB, 24'd0);
		track(1000, 0, 0);
		hit(1000, 0, 0, 16777215, 4, 0);
		hit(1000, 0, 0, 16777215, 4, 0);
		hit(1000, 0, 0, 16777215, 4, 1);
		// The sum is kept after last and stays clamped.
		hit(1000, 0, 0, 3000, 0, 1);
		track(1000, 0, 0);
		hit(1000, 0, 0, 3000, 4, 1);
		drain();
	endtask

	// Events of an optional track and several hits, most of them close to the track direction.
	task automatic random_events(int count);
		int tx, ty, tz, n, spread;
		int done;
		done = 0;
		while (done < count) begin
			if ($urandom_range(9) == 0) begin
				hit(rand_pos(), rand_pos(), rand_pos(), $urandom() >> 8, $urandom_range(7),
					$urandom_range(1));
				done++;
				continue;
			end
			tx = rand_pos() >>> $urandom_range(8);
			ty = rand_pos() >>> $urandom_range(8);
			tz = rand_pos() >>> $urandom_range(8);
			if ($urandom_range(3) != 0) track(tx, ty, tz);
			n = $urandom_range(8, 1);
			spread = ($urandom_range(1) != 0) ? 64 : 8;
			for (int k = 0; k < n; k++) begin
				hit(jitter(tx, spread), jitter(ty, spread), jitter(tz, spread),
					($urandom_range(4) == 0) ? $urandom() >> 8 : $urandom_range(20000),
					$urandom_range(7), (k == n - 1) || ($urandom_range(15) == 0));
			end
			done += n + 1;
		end
		drain();
	endtask

	task automatic test_random_defaults();
		random_events(130);
	endtask

	task automatic test_random_wide_cone();
		write_reg(REG_CONE_RADIUS, 16'd65535);
		write_reg(REG_HIT_THRESHOLD, 24'd0);
		write_reg(REG_GAIN_EB, 24'd69941);
		write_reg(REG_GAIN_EE, 24'hFFFFFF);
		write_reg(REG_GAIN_HB, 24'd1);
		write_reg(REG_GAIN_HE, 24'd3514456);
		write_reg(REG_GAIN_HR, 24'd4077219);
		random_events(120);
	endtask

	task automatic test_random_tight_cone();
		write_reg(REG_CONE_RADIUS, 16'd0);
		write_reg(REG_HIT_THRESHOLD, 24'hFFFFFF);
		random_events(30);
		write_reg(REG_CONE_RADIUS, 16'd2000);
		write_reg(REG_HIT_THRESHOLD, 24'd5000);
		write_reg(REG_GAIN_HB, 24'd3224573);
		calm = 1;
		random_events(80);
		calm = 0;
		random_events(60);
	endtask

	always @(negedge clk) begin
		out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin
		cone_sum_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			sums_seen++;
			if (pending_sums.size() == 0) begin
				$error("cone sum with no transaction pending: cone_energy %0d", out_ch.cone_energy);
				err_cnt++;
			end else begin
				want = pending_sums.pop_front();
				if (out_ch.cone_energy !== want.energy) begin
					$error("cone_energy expected %0d actual %0d", want.energy, out_ch.cone_energy);
					err_cnt++;
				end
				if (out_ch.saturated !== want.sat) begin
					$error("saturated expected %0d actual %0d", want.sat, out_ch.saturated);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CONE_RADIUS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.hit_energy = '0;
		in_ch.subdetector = '0;
		in_ch.last = 1'b0;
		mdl_radius = RST_CONE_RADIUS;
		mdl_threshold = RST_HIT_THRESHOLD;
		mdl_gain[0] = RST_GAIN_EB;
		mdl_gain[1] = RST_GAIN_EE;
		mdl_gain[2] = RST_GAIN_HB;
		mdl_gain[3] = RST_GAIN_HE;
		mdl_gain[4] = RST_GAIN_HR;
		trk_eta = 0;
		trk_phi = 0;
		run_sum = 0;
		run_ovf = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (200) @(posedge clk);

		test_directed();
		test_random_defaults();
		test_overflow();
		test_random_wide_cone();
		test_random_tight_cone();

		$display("Sent %0d transactions, checked %0d cone sums, %0d hits fell inside the cone.",
			items_sent, sums_seen, hits_in_cone);
		$display("Covered origin, beam axis, unknown subdetectors, saturation and register extremes.");
		if (err_cnt == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
